[hw/rtl/hmbf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hmbf_pkg
// Shared types, constants and helper functions of the HTTP message body framer.
// ----------------------------------------------------------------------------
package hmbf_pkg;

  // length and chunk size limits
  localparam int LENGTH_BITS    = 32;
  localparam int MAX_HEX_DIGITS = 8;
  localparam int ACC_W          = 4 * MAX_HEX_DIGITS;
  localparam int REM_W          = (LENGTH_BITS > ACC_W) ? LENGTH_BITS : ACC_W;
  localparam int HEX_CNT_W      = $clog2(MAX_HEX_DIGITS + 1);

  // field names and the coding word
  localparam int TE_LEN = 18;
  localparam int CL_LEN = 15;
  localparam int CK_LEN = 7;
  localparam logic [8*TE_LEN-1:0] TE_NAME = "Transfer-Encoding:";
  localparam logic [8*CL_LEN-1:0] CL_NAME = "Content-Length:";
  localparam logic [8*CK_LEN-1:0] CK_WORD = "chunked";

  // character codes
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LF_X = 8'h66;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;

  typedef enum logic [2:0] {
    PH_HEAD  = 3'd0,
    PH_SIZE  = 3'd1,
    PH_DATA  = 3'd2,
    PH_TRAIL = 3'd3,
    PH_BODY  = 3'd4,
    PH_DONE  = 3'd5,
    PH_ERR   = 3'd6
  } phase_t;

  // header field scanner states
  typedef enum logic [1:0] {TE_IDLE, TE_VALUE, TE_DONE} te_st_t;
  typedef enum logic [1:0] {CL_IDLE, CL_BLANK, CL_DIGITS, CL_DONE} cl_st_t;

  // header scanner status, next-state view
  typedef struct packed {
    logic                   hdr_end;
    logic                   chunked;
    logic                   cl_seen;
    logic                   len_bad;
    logic [LENGTH_BITS-1:0] cl_value;
  } hdr_stat_t;

  // one result
  typedef struct packed {
    logic       body_valid;
    logic [7:0] body_byte;
    phase_t     phase;
    logic       chunked_mode;
    logic       length_error;
    logic       accepted;
  } result_t;

  function automatic logic [7:0] te_char(input logic [4:0] idx);
    te_char = TE_NAME[8*(TE_LEN-1-int'(idx)) +: 8];
  endfunction

  function automatic logic [7:0] cl_char(input logic [3:0] idx);
    cl_char = CL_NAME[8*(CL_LEN-1-int'(idx)) +: 8];
  endfunction

  function automatic logic [7:0] ck_char(input logic [2:0] idx);
    ck_char = CK_WORD[8*(CK_LEN-1-int'(idx)) +: 8];
  endfunction

  // {ok, value} of one hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [7:0] t;
    t = 8'h00;
    hex_decode = 5'b0_0000;
    if (b >= CH_0 && b <= CH_9) begin
      t = b - CH_0;
      hex_decode = {1'b1, t[3:0]};
    end else if (b >= CH_LA && b <= CH_LF_X) begin
      t = b - CH_LA + 8'd10;
      hex_decode = {1'b1, t[3:0]};
    end else if (b >= CH_UA && b <= CH_UF) begin
      t = b - CH_UA + 8'd10;
      hex_decode = {1'b1, t[3:0]};
    end
  endfunction

endpackage
`default_nettype wire

[hw/rtl/hmbf_hdr_scan.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hmbf_hdr_scan
// Header matchers: header end, Transfer-Encoding value, Content-Length value.
// ----------------------------------------------------------------------------
module hmbf_hdr_scan (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic [7:0]        data_byte,
  output hmbf_pkg::hdr_stat_t    stat
);
  import hmbf_pkg::*;

  localparam int CLP_W = LENGTH_BITS + 4;

  te_st_t                 te_st_r, te_st_nxt;
  cl_st_t                 cl_st_r, cl_st_nxt;
  logic [4:0]             te_idx_r, te_idx_nxt;
  logic [2:0]             ck_idx_r, ck_idx_nxt;
  logic                   ck_found_r, ck_found_nxt;
  logic [3:0]             cl_idx_r, cl_idx_nxt;
  logic [LENGTH_BITS-1:0] cl_val_r, cl_val_nxt;
  logic                   cl_bad_r, cl_bad_nxt;
  logic [1:0]             he_r, he_nxt;
  logic                   hdr_end;
  logic                   is_digit;
  logic [7:0]             digit;
  logic [CLP_W-1:0]       prod;
  logic [7:0]             he_want;

  assign is_digit = (data_byte >= CH_0) && (data_byte <= CH_9);
  assign digit    = data_byte - CH_0;
  // value * 10 + digit, overflow shows in the top bits
  assign prod = ({4'b0000, cl_val_r} << 3) + ({4'b0000, cl_val_r} << 1)
              + CLP_W'(digit);
  assign he_want = he_r[0] ? CH_LF : CH_CR;

  always_comb begin
    te_st_nxt    = te_st_r;
    te_idx_nxt   = te_idx_r;
    ck_idx_nxt   = ck_idx_r;
    ck_found_nxt = ck_found_r;
    cl_st_nxt    = cl_st_r;
    cl_idx_nxt   = cl_idx_r;
    cl_val_nxt   = cl_val_r;
    cl_bad_nxt   = cl_bad_r;
    he_nxt       = he_r;
    hdr_end      = 1'b0;
    if (en) begin
      // transfer-encoding
      case (te_st_r)
        TE_IDLE: begin
          if (data_byte == te_char(te_idx_r)) begin
            if (te_idx_r == 5'(TE_LEN - 1)) begin
              te_st_nxt  = TE_VALUE;
              te_idx_nxt = 5'd0;
            end else begin
              te_idx_nxt = te_idx_r + 5'd1;
            end
          end else begin
            te_idx_nxt = (data_byte == te_char(5'd0)) ? 5'd1 : 5'd0;
          end
        end
        TE_VALUE: begin
          if (data_byte == CH_CR) begin
            te_st_nxt = TE_DONE;
          end else if (!ck_found_r) begin
            if (data_byte == ck_char(ck_idx_r)) begin
              if (ck_idx_r == 3'(CK_LEN - 1)) begin
                ck_found_nxt = 1'b1;
                ck_idx_nxt   = 3'd0;
              end else begin
                ck_idx_nxt = ck_idx_r + 3'd1;
              end
            end else begin
              ck_idx_nxt = (data_byte == ck_char(3'd0)) ? 3'd1 : 3'd0;
            end
          end
        end
        default: ;
      endcase

      // content-length
      case (cl_st_r)
        CL_IDLE: begin
          if (data_byte == cl_char(cl_idx_r)) begin
            if (cl_idx_r == 4'(CL_LEN - 1)) begin
              cl_st_nxt  = CL_BLANK;
              cl_idx_nxt = 4'd0;
            end else begin
              cl_idx_nxt = cl_idx_r + 4'd1;
            end
          end else begin
            cl_idx_nxt = (data_byte == cl_char(4'd0)) ? 4'd1 : 4'd0;
          end
        end
        CL_BLANK, CL_DIGITS: begin
          if (is_digit) begin
            if (prod[CLP_W-1:LENGTH_BITS] != 4'd0) begin
              cl_bad_nxt = 1'b1;
              cl_st_nxt  = CL_DONE;
            end else begin
              cl_val_nxt = prod[LENGTH_BITS-1:0];
              cl_st_nxt  = CL_DIGITS;
            end
          end else if (cl_st_r == CL_BLANK &&
                       (data_byte == CH_SP || data_byte == CH_TAB)) begin
            cl_st_nxt = CL_BLANK;
          end else begin
            if (cl_st_r == CL_BLANK) cl_bad_nxt = 1'b1;
            cl_st_nxt = CL_DONE;
          end
        end
        default: ;
      endcase

      // cr lf cr lf
      if (data_byte == he_want) begin
        if (he_r == 2'd3) begin
          he_nxt  = 2'd0;
          hdr_end = 1'b1;
        end else begin
          he_nxt = he_r + 2'd1;
        end
      end else begin
        he_nxt = (data_byte == CH_CR) ? 2'd1 : 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      te_st_r    <= TE_IDLE;
      te_idx_r   <= 5'd0;
      ck_idx_r   <= 3'd0;
      ck_found_r <= 1'b0;
      cl_st_r    <= CL_IDLE;
      cl_idx_r   <= 4'd0;
      cl_val_r   <= '0;
      cl_bad_r   <= 1'b0;
      he_r       <= 2'd0;
    end else begin
      te_st_r    <= te_st_nxt;
      te_idx_r   <= te_idx_nxt;
      ck_idx_r   <= ck_idx_nxt;
      ck_found_r <= ck_found_nxt;
      cl_st_r    <= cl_st_nxt;
      cl_idx_r   <= cl_idx_nxt;
      cl_val_r   <= cl_val_nxt;
      cl_bad_r   <= cl_bad_nxt;
      he_r       <= he_nxt;
    end
  end

  assign stat.hdr_end  = hdr_end;
  assign stat.chunked  = ck_found_nxt;
  assign stat.cl_seen  = (cl_st_nxt != CL_IDLE);
  assign stat.len_bad  = cl_bad_nxt || (cl_st_nxt == CL_BLANK);
  assign stat.cl_value = cl_val_nxt;

endmodule
`default_nettype wire

[hw/rtl/hmbf_body_fsm.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hmbf_body_fsm
// Phase sequencer: body length countdown and chunked size/data/trailer steps.
// ----------------------------------------------------------------------------
module hmbf_body_fsm (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [7:0]        data_byte,
  input  hmbf_pkg::hdr_stat_t    hdr,
  output logic                   in_head,
  output hmbf_pkg::result_t      res
);
  import hmbf_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [HEX_CNT_W-1:0] hcnt_r, hcnt_nxt;
  logic                 cr_r, cr_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic                 trail_r, trail_nxt;
  logic                 chunked_r, chunked_nxt;
  logic                 len_err_r, len_err_nxt;
  logic [4:0]           hex;
  logic [REM_W-1:0]     rem_dec;

  assign in_head = (phase_r == PH_HEAD);
  assign hex     = hex_decode(data_byte);
  assign rem_dec = rem_r - REM_W'(rem_r != '0);

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    acc_nxt     = acc_r;
    hcnt_nxt    = hcnt_r;
    cr_nxt      = cr_r;
    rem_nxt     = rem_r;
    trail_nxt   = trail_r;
    chunked_nxt = chunked_r;
    len_err_nxt = len_err_r;
    if (step) begin
      case (phase_r)
        PH_HEAD: begin
          if (hdr.hdr_end) begin
            if (hdr.chunked) begin
              phase_nxt   = PH_SIZE;
              chunked_nxt = 1'b1;
              acc_nxt     = '0;
              hcnt_nxt    = '0;
              cr_nxt      = 1'b0;
            end else if (hdr.cl_seen) begin
              if (hdr.len_bad) begin
                len_err_nxt = 1'b1;
                phase_nxt   = PH_DONE;
              end else if (hdr.cl_value == '0) begin
                phase_nxt = PH_DONE;
              end else begin
                rem_nxt   = REM_W'(hdr.cl_value);
                phase_nxt = PH_BODY;
              end
            end else begin
              phase_nxt = PH_DONE;
            end
          end
        end
        PH_SIZE: begin
          if (cr_r) begin
            cr_nxt = 1'b0;
            if (data_byte != CH_LF || hcnt_r == '0) begin
              phase_nxt = PH_ERR;
            end else if (acc_r == '0) begin
              phase_nxt = PH_TRAIL;
              trail_nxt = 1'b0;
            end else begin
              rem_nxt   = REM_W'(acc_r);
              trail_nxt = 1'b0;
              phase_nxt = PH_DATA;
            end
          end else if (data_byte == CH_CR) begin
            cr_nxt = 1'b1;
          end else if (!hex[4] || hcnt_r >= HEX_CNT_W'(MAX_HEX_DIGITS)) begin
            phase_nxt = PH_ERR;
          end else begin
            acc_nxt  = (acc_r << 4) | ACC_W'(hex[3:0]);
            hcnt_nxt = hcnt_r + HEX_CNT_W'(1);
          end
        end
        PH_DATA: begin
          if (rem_r != '0) begin
            rem_nxt = rem_dec;
          end else if (!trail_r) begin
            trail_nxt = 1'b1;
          end else begin
            trail_nxt = 1'b0;
            acc_nxt   = '0;
            hcnt_nxt  = '0;
            cr_nxt    = 1'b0;
            phase_nxt = PH_SIZE;
          end
        end
        PH_TRAIL: begin
          if (!trail_r) begin
            if (data_byte == CH_CR) trail_nxt = 1'b1;
            else                    phase_nxt = PH_ERR;
          end else begin
            trail_nxt = 1'b0;
            phase_nxt = (data_byte == CH_LF) ? PH_DONE : PH_ERR;
          end
        end
        PH_BODY: begin
          rem_nxt = rem_dec;
          if (rem_dec == '0) phase_nxt = PH_DONE;
        end
        default: ;
      endcase
    end
  end

  // result fields
  always_comb begin
    res.body_valid   = 1'b0;
    res.accepted     = 1'b1;
    case (phase_r)
      PH_DATA:  res.body_valid = (rem_r != '0);
      PH_BODY:  res.body_valid = 1'b1;
      PH_HEAD, PH_SIZE, PH_TRAIL: ;
      default:  res.accepted = 1'b0;
    endcase
    res.body_byte    = res.body_valid ? data_byte : 8'h00;
    res.phase        = phase_nxt;
    res.chunked_mode = chunked_nxt;
    res.length_error = len_err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEAD;
      acc_r     <= '0;
      hcnt_r    <= '0;
      cr_r      <= 1'b0;
      rem_r     <= '0;
      trail_r   <= 1'b0;
      chunked_r <= 1'b0;
      len_err_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      acc_r     <= acc_nxt;
      hcnt_r    <= hcnt_nxt;
      cr_r      <= cr_nxt;
      rem_r     <= rem_nxt;
      trail_r   <= trail_nxt;
      chunked_r <= chunked_nxt;
      len_err_r <= len_err_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/http_message_body_framer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// http_message_body_framer
// Byte-serial HTTP request framer: header scan, Content-Length body pass and
// chunked transfer decoding, one result per request byte.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | in_data_byte
//  out     | out_valid / out_ready| out_out_valid, out_out_byte, out_phase,
//          |                      | out_chunked_mode, out_length_error,
//          |                      | out_accepted
//
//  one request per cycle sustained while the receiver takes every result;
//  a request passes the input register, then the step logic into the result
//  register; the step rate is set by the update of the phase sequencer
//  reset: synchronous, active low; phase starts in header scan
//  a stalled result holds in the result register; the input register keeps
//  taking a request and stalls only when both stages are full
// ----------------------------------------------------------------------------
module http_message_body_framer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_out_valid,
  output logic [7:0]      out_out_byte,
  output logic [2:0]      out_phase,
  output logic            out_chunked_mode,
  output logic            out_length_error,
  output logic            out_accepted
);
  import hmbf_pkg::*;

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  // result register
  logic       out_valid_r, out_valid_nxt;
  result_t    res_r;

  logic       advance;
  logic       in_head;
  hdr_stat_t  hdr;
  result_t    res;

  // step the framer when a byte waits and the result slot is free or draining
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) s1_valid_nxt = 1'b1;
    else if (advance)         s1_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance)        out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_byte_r <= in_data_byte;
    if (advance)              res_r     <= res;
  end

  // header matchers only move while in header scan
  hmbf_hdr_scan u_hdr_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance && in_head),
    .data_byte (s1_byte_r),
    .stat      (hdr)
  );

  // phase sequencer and result formation
  hmbf_body_fsm u_body_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (s1_byte_r),
    .hdr       (hdr),
    .in_head   (in_head),
    .res       (res)
  );

  assign out_valid        = out_valid_r;
  assign out_out_valid    = res_r.body_valid;
  assign out_out_byte     = res_r.body_byte;
  assign out_phase        = res_r.phase;
  assign out_chunked_mode = res_r.chunked_mode;
  assign out_length_error = res_r.length_error;
  assign out_accepted     = res_r.accepted;

endmodule
`default_nettype wire

[hw/rtl/hmbf_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hmbf_checker
// Port-level checks of the framer's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module hmbf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_out_valid,
  input wire logic [7:0] out_out_byte,
  input wire logic [2:0] out_phase,
  input wire logic       out_chunked_mode,
  input wire logic       out_length_error,
  input wire logic       out_accepted
);
  import hmbf_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_out_byte) &&
    $stable(out_phase) && $stable(out_out_valid))
    else $error("result changed while stalled");

  // body bytes only come out of data, body or a just-finished body
  a_body_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_valid |->
    (out_phase == PH_DATA || out_phase == PH_BODY || out_phase == PH_DONE))
    else $error("body byte outside a body phase");

  // a refused request leaves a terminal phase and no body byte
  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |->
    (out_phase == PH_DONE || out_phase == PH_ERR) && !out_out_valid)
    else $error("request refused outside complete or error");

  // chunked coding masks a length error
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_chunked_mode |-> !out_length_error)
    else $error("length error flagged in chunked mode");

  // no mode flags while headers are still arriving
  a_head_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_phase == PH_HEAD |-> !out_chunked_mode && !out_length_error)
    else $error("mode flag set during header scan");

endmodule

bind http_message_body_framer hmbf_checker u_hmbf_checker (.*);
`default_nettype wire

[test/http_message_body_framer_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// http_message_body_framer_test
// Streams one HTTP request into the framer byte by byte. Header fields come
// first (plain and near-miss names), then header noise, then the body:
// chunked, Content-Length, a bad length or none. The chunked body ends in a
// good final line or in one of the size-line faults, and refused bytes
// follow. A byte-level model of the framer predicts every result, and each
// result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module http_message_body_framer_test;
  import hmbf_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int BODY_ITEMS   = 850;   // where the random part of the stream stops
  localparam int IDLE_STRETCH = 100;   // requests per idling phase
  localparam int IDLE_HEAVY   = 76;
  localparam int IDLE_LIGHT   = 17;
  localparam int SETTLE_CYCLES = 10;   // wait after the last result before the verdict

  // request framing chosen for the run
  typedef enum int {REQ_CHUNKED, REQ_LENGTH, REQ_BAD_LENGTH, REQ_NO_BODY} request_kind_t;
  // how the chunked body ends
  typedef enum int {
    END_FINAL_CRLF, END_BAD_FINAL, END_NON_HEX, END_LONG_SIZE, END_BARE_CR,
    END_EMPTY_SIZE, END_HUGE_CHUNK
  } chunk_end_t;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // header field scanner states
  typedef enum logic [1:0] {TE_UNSEEN, TE_VALUE, TE_DONE} te_state_t;
  typedef enum logic [1:0] {CL_UNSEEN, CL_BLANKS, CL_DIGITS, CL_DONE} cl_state_t;

  localparam string TE_FIELD_TEXT = "Transfer-Encoding:";
  localparam string CL_FIELD_TEXT = "Content-Length:";
  localparam string CK_WORD_TEXT  = "chunked";

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_out_valid;
  logic [7:0] out_out_byte;
  logic [2:0] out_phase;
  logic       out_chunked_mode;
  logic       out_length_error;
  logic       out_accepted;

  http_message_body_framer DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_out_valid    (out_out_valid),
    .out_out_byte     (out_out_byte),
    .out_phase        (out_phase),
    .out_chunked_mode (out_chunked_mode),
    .out_length_error (out_length_error),
    .out_accepted     (out_accepted)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // framer state as the stream has moved it so far
  phase_t      fr_phase   = PH_HEAD;
  int unsigned crlf_count = 0;
  int unsigned te_idx     = 0;
  int unsigned ck_idx     = 0;
  int unsigned cl_idx     = 0;
  te_state_t   te_state   = TE_UNSEEN;
  cl_state_t   cl_state   = CL_UNSEEN;
  logic        ck_found   = 1'b0;
  logic        cl_bad     = 1'b0;
  logic [63:0] cl_val     = '0;
  logic [63:0] size_acc   = '0;
  logic [63:0] remaining  = '0;
  int unsigned hex_count  = 0;
  logic        size_cr    = 1'b0;
  logic        trail_cnt  = 1'b0;

  result_t    step_results[$];   // results owed by the framer, oldest first
  int         item_count  = 0;
  int         error_count = 0;
  int         cycle_count = 0;
  idle_mode_t idle_mode   = IDLE_NONE;

  // one step of a name matcher; the first letter occurs once in each pattern
  function automatic int unsigned advance_match(int unsigned idx, string pat, logic [7:0] b);
    if (idx < pat.len() && b == pat[idx]) return idx + 1;
    return (b == pat[0]) ? 1 : 0;
  endfunction

  function automatic int hex_nibble(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - 8'h30);
    if (b >= "a" && b <= "f") return int'(b - 8'h61) + 10;
    if (b >= "A" && b <= "F") return int'(b - 8'h41) + 10;
    return -1;
  endfunction

  function automatic void scan_header_byte(logic [7:0] b);
    logic [7:0]  want;
    logic [63:0] digit;
    logic [63:0] len_max;
    len_max = (LENGTH_BITS >= 64) ? '1 : ((64'd1 << LENGTH_BITS) - 64'd1);

    // transfer coding name, then look for the coding word up to the CR
    if (te_state == TE_UNSEEN) begin
      te_idx = advance_match(te_idx, TE_FIELD_TEXT, b);
      if (te_idx == TE_LEN) begin
        te_state = TE_VALUE;
        te_idx = 0;
      end
    end else if (te_state == TE_VALUE) begin
      if (b == CH_CR) begin
        te_state = TE_DONE;
      end else if (!ck_found) begin
        ck_idx = advance_match(ck_idx, CK_WORD_TEXT, b);
        if (ck_idx == CK_LEN) begin
          ck_found = 1'b1;
          ck_idx = 0;
        end
      end
    end

    // length name, leading blanks, then decimal digits with overflow guard
    if (cl_state == CL_UNSEEN) begin
      cl_idx = advance_match(cl_idx, CL_FIELD_TEXT, b);
      if (cl_idx == CL_LEN) begin
        cl_state = CL_BLANKS;
        cl_idx = 0;
      end
    end else if (cl_state == CL_BLANKS || cl_state == CL_DIGITS) begin
      if (b >= "0" && b <= "9") begin
        digit = 64'(b - 8'h30);
        if (digit > len_max || cl_val > (len_max - digit) / 64'd10) begin
          cl_bad = 1'b1;
          cl_state = CL_DONE;
        end else begin
          cl_val = cl_val * 64'd10 + digit;
          cl_state = CL_DIGITS;
        end
      end else if (!(cl_state == CL_BLANKS && (b == CH_SP || b == CH_TAB))) begin
        if (cl_state == CL_BLANKS) cl_bad = 1'b1;
        cl_state = CL_DONE;
      end
    end

    // blank line detection, then pick the body framing
    want = crlf_count[0] ? CH_LF : CH_CR;
    if (b == want) crlf_count = crlf_count + 1;
    else crlf_count = (b == CH_CR) ? 1 : 0;
    if (crlf_count == 4) begin
      crlf_count = 0;
      if (ck_found) begin
        fr_phase = PH_SIZE;
        size_acc = '0;
        hex_count = 0;
        size_cr = 1'b0;
      end else if (cl_state != CL_UNSEEN) begin
        if (cl_bad || cl_state == CL_BLANKS) begin
          cl_bad = 1'b1;
          fr_phase = PH_DONE;
        end else if (cl_val == 0) begin
          fr_phase = PH_DONE;
        end else begin
          remaining = cl_val;
          fr_phase = PH_BODY;
        end
      end else begin
        fr_phase = PH_DONE;
      end
    end
  endfunction

  // advance the framer by one request byte and queue the result it owes
  function automatic void frame_request_byte(logic [7:0] b);
    result_t r;
    int      h;
    r = '0;
    r.accepted = 1'b1;
    case (fr_phase)
      PH_HEAD: scan_header_byte(b);
      PH_SIZE: begin
        if (size_cr) begin
          size_cr = 1'b0;
          if (b != CH_LF || hex_count == 0) begin
            fr_phase = PH_ERR;
          end else if (size_acc == 0) begin
            fr_phase = PH_TRAIL;
            trail_cnt = 1'b0;
          end else begin
            remaining = size_acc;
            trail_cnt = 1'b0;
            fr_phase = PH_DATA;
          end
        end else if (b == CH_CR) begin
          size_cr = 1'b1;
        end else begin
          h = hex_nibble(b);
          if (h < 0 || hex_count >= MAX_HEX_DIGITS || hex_count >= 16) begin
            fr_phase = PH_ERR;
          end else begin
            size_acc = {size_acc[59:0], 4'(h)};
            hex_count++;
          end
        end
      end
      PH_DATA: begin
        if (remaining > 0) begin
          r.body_valid = 1'b1;
          r.body_byte = b;
          remaining--;
        end else if (!trail_cnt) begin
          trail_cnt = 1'b1;   // first of the two bytes after the data, not checked
        end else begin
          trail_cnt = 1'b0;
          size_acc = '0;
          hex_count = 0;
          size_cr = 1'b0;
          fr_phase = PH_SIZE;
        end
      end
      PH_TRAIL: begin
        // the line after the zero-size chunk must be exactly CR LF
        if (!trail_cnt) begin
          if (b == CH_CR) trail_cnt = 1'b1;
          else fr_phase = PH_ERR;
        end else begin
          trail_cnt = 1'b0;
          fr_phase = (b == CH_LF) ? PH_DONE : PH_ERR;
        end
      end
      PH_BODY: begin
        r.body_valid = 1'b1;
        r.body_byte = b;
        if (remaining > 0) remaining--;
        if (remaining == 0) fr_phase = PH_DONE;
      end
      default: r.accepted = 1'b0;   // complete or error: byte refused
    endcase
    r.phase = fr_phase;
    r.chunked_mode = ck_found && fr_phase != PH_HEAD;
    r.length_error = cl_bad && !ck_found && fr_phase != PH_HEAD;
    step_results = {step_results, r};
  endfunction

  // one request on the input channel, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    int idle_pct;
    idle_pct = (idle_mode == IDLE_SENDER) ? IDLE_HEAVY :
               (idle_mode == IDLE_BOTH) ? IDLE_LIGHT : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    frame_request_byte(b);
    item_count++;
    idle_mode = idle_mode_t'((item_count / IDLE_STRETCH) % 4);
  endtask

  task automatic send_line(input string text);
    for (int i = 0; i < text.len(); i++) send_byte(text[i]);
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  // hex size digits, zero padded to width, random letter case
  task automatic send_chunk_size(input logic [63:0] value, input int width);
    logic [3:0] nib;
    logic [7:0] c;
    for (int i = width - 1; i >= 0; i--) begin
      nib = value[4*i +: 4];
      if (nib < 4'd10) c = 8'h30 + 8'(nib);
      else c = ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
      send_byte(c);
    end
  endtask

  // hold the sender off until every owed result has come
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (step_results.size() != 0) @(posedge clk);
  endtask

  // byte extremes, near-miss names, a partial blank line, then the real fields
  task automatic test_header_fields(input request_kind_t kind, input int body_len);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h7f);
    send_byte(8'h80);
    send_line("Transfer-Encodin:");
    send_line("Content-Lengt: 3");
    send_byte(CH_CR);   // CR LF CR then a letter is not the header end
    send_byte("x");
    case (kind)
      REQ_CHUNKED: begin
        // largest valid length, overridden by the chunked coding
        send_line("Content-Length: 4294967295");
        send_line("Transfer-Encoding: gzip, chunkchunked");
      end
      REQ_LENGTH: begin
        send_line("Transfer-Encoding: gzip");
        send_line($sformatf("Content-Length: \t %0d", body_len));
        send_line("Content-Length: 7");   // only the first field counts
      end
      REQ_BAD_LENGTH: begin
        case ($urandom_range(4))
          0: send_line("Content-Length: +5");
          1: send_line("Content-Length: -5");
          2: send_line("Content-Length: ");
          3: send_line("Content-Length: 4294967296");
          default: send_line("Content-Length: 99999999999x");
        endcase
      end
      default: begin
        if ($urandom_range(1)) send_line("Content-Length: 0");
        else send_line("Host: x");
      end
    endcase
  endtask

  // random header bytes that never close the header early, then the blank line
  task automatic test_header_noise(input int count);
    logic [7:0] b;
    repeat (count) begin
      case ($urandom_range(9))
        0: b = CH_CR;
        1: b = CH_LF;
        2, 3: b = 8'($urandom_range(255));
        default: b = 8'($urandom_range(126, 32));
      endcase
      if (b == CH_LF && crlf_count == 3) b = "x";
      send_byte(b);
    end
    send_byte("h");
    send_line("");
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  task automatic test_length_body(input int body_len);
    repeat (body_len) send_byte(8'($urandom_range(255)));
  endtask

  // well-formed chunks with random sizes, padding, case and data
  task automatic test_chunked_body();
    int size;
    while (item_count < BODY_ITEMS) begin
      size = $urandom_range(40, 1);
      send_chunk_size(64'(size), $urandom_range(MAX_HEX_DIGITS, (size > 15) ? 2 : 1));
      send_byte(CH_CR);
      send_byte(CH_LF);
      repeat (size) send_byte(8'($urandom_range(255)));
      // the two bytes after the data are skipped, so they need not be CR LF
      if ($urandom_range(7) == 0) begin
        send_byte(8'($urandom_range(255)));
        send_byte(8'($urandom_range(255)));
      end else begin
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
    end
  endtask

  task automatic test_chunk_end();
    chunk_end_t end_kind;
    logic [7:0] b;
    if ($urandom_range(1)) end_kind = END_FINAL_CRLF;
    else end_kind = chunk_end_t'($urandom_range(END_HUGE_CHUNK, END_BAD_FINAL));
    case (end_kind)
      END_FINAL_CRLF, END_BAD_FINAL: begin
        send_chunk_size(64'd0, $urandom_range(MAX_HEX_DIGITS, 1));
        send_byte(CH_CR);
        send_byte(CH_LF);
        if (end_kind == END_FINAL_CRLF) begin
          send_byte(CH_CR);
          send_byte(CH_LF);
        end else if ($urandom_range(1)) begin
          send_byte("x");
        end else begin
          send_byte(CH_CR);
          send_byte("y");
        end
      end
      END_NON_HEX: begin
        if ($urandom_range(1)) send_byte("7");
        do b = 8'($urandom_range(255)); while (hex_nibble(b) >= 0 || b == CH_CR);
        send_byte(b);
      end
      END_LONG_SIZE: send_chunk_size(64'd1, MAX_HEX_DIGITS + 1);
      END_BARE_CR: begin
        send_chunk_size(64'($urandom_range(15, 1)), 1);
        send_byte(CH_CR);
        do b = 8'($urandom_range(255)); while (b == CH_LF);
        send_byte(b);
      end
      END_EMPTY_SIZE: begin
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
      default: begin
        // widest size the line allows; the chunk outlasts the run
        send_chunk_size(64'hffff_ffff, MAX_HEX_DIGITS);
        send_byte(CH_CR);
        send_byte(CH_LF);
        repeat (20) send_byte(8'($urandom_range(255)));
      end
    endcase
  endtask

  // once complete or in error every byte is refused and nothing moves
  task automatic test_refused_bytes();
    repeat (12) send_byte(8'($urandom_range(255)));
  endtask

  function automatic void check_field(string name, logic [7:0] actual, logic [7:0] expected);
    if (actual !== expected) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expected, actual);
      error_count++;
    end
  endfunction

  // receiver side: random stalls following the idling phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= ((idle_mode == IDLE_RECEIVER) ? IDLE_HEAVY :
                                         (idle_mode == IDLE_BOTH) ? IDLE_LIGHT : 0));
  end

  // compare every accepted result with the oldest one owed
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (step_results.size() == 0) begin
        $display("%0t: unexpected result, phase %0d byte %0h", $time, out_phase,
                 out_out_byte);
        error_count++;
      end else begin
        want = step_results.pop_front();
        check_field("out_valid", out_out_valid, want.body_valid);
        check_field("out_byte", out_out_byte, want.body_byte);
        check_field("phase", out_phase, want.phase);
        check_field("chunked_mode", out_chunked_mode, want.chunked_mode);
        check_field("length_error", out_length_error, want.length_error);
        check_field("accepted", out_accepted, want.accepted);
      end
    end
  end

  // hard stop if the handshakes hang
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : run_request
    request_kind_t kind;
    int            pick;
    int            body_len;
    pick = $urandom_range(99);
    if (pick < 55) kind = REQ_CHUNKED;
    else if (pick < 80) kind = REQ_LENGTH;
    else if (pick < 90) kind = REQ_BAD_LENGTH;
    else kind = REQ_NO_BODY;
    // header part of a length request is a little over two hundred bytes
    body_len = $urandom_range(640, 590);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_header_fields(kind, body_len);
    // bodyless requests spend the random part in the header scanner
    test_header_noise((kind == REQ_CHUNKED || kind == REQ_LENGTH) ? 120 :
                      BODY_ITEMS - item_count);
    drain_results();
    case (kind)
      REQ_CHUNKED: begin
        test_chunked_body();
        test_chunk_end();
      end
      REQ_LENGTH: test_length_body(body_len);
      default: ;
    endcase
    test_refused_bytes();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
